// ===== hw/rtl/aabb_pkg.sv =====
// aabb_pkg: constants, payload types and helpers for the pairwise box overlap unit
// no dependencies; used by every other file of the block
`default_nettype none
package aabb_pkg;

	localparam int MAX_BOXES   = 64;
	localparam int COORD_BITS  = 32;
	localparam int FIELD_W     = 32;
	localparam int OUT_IDX_W   = 6;
	localparam int MARGIN_W    = 31;
	localparam int IDX_W       = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W       = $clog2(MAX_BOXES + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W       = ((COORD_BITS > MARGIN_W) ? COORD_BITS : MARGIN_W) + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] min_x;
		logic signed [FIELD_W-1:0] min_y;
		logic signed [FIELD_W-1:0] min_z;
		logic signed [FIELD_W-1:0] max_x;
		logic signed [FIELD_W-1:0] max_y;
		logic signed [FIELD_W-1:0] max_z;
		logic                      first_of_frame;
	} box_in_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] earlier_index;
		logic [OUT_IDX_W-1:0] later_index;
		logic                 overflow;
		logic                 last;
	} result_t;

	typedef struct packed {
		coord_t [2:0] lo;
		coord_t [2:0] hi;
	} entry_t;

	typedef struct packed {
		entry_t           box;
		logic [IDX_W-1:0] idx;
		logic             overflow;
	} cmd_t;

	// low COORD_BITS bits of a field, read as signed
	function automatic coord_t coord_of(input logic [FIELD_W-1:0] raw);
		coord_t r;
		r = '0;
		for (int i = 0; i < COORD_BITS; i++) begin
			r[i] = raw[(i < FIELD_W) ? i : FIELD_W - 1];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aabb_if.sv =====
// aabb_box_if and aabb_pair_if: valid/ready channels for boxes in and pairs out
// depends on aabb_pkg for the payload types
`default_nettype none
interface aabb_box_if;
	logic              valid;
	logic              ready;
	aabb_pkg::box_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aabb_pair_if;
	logic              valid;
	logic              ready;
	aabb_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/aabb_front.sv =====
// aabb_front: accepts boxes, keeps the frame box count, tags each box with
// its index or as overflow; depends on aabb_pkg and aabb_if
`default_nettype none
module aabb_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	aabb_box_if.sink            box_in,
	output aabb_pkg::cmd_t      push_data,
	output logic                push_valid,
	input  wire logic           push_ready
);

	logic [aabb_pkg::CNT_W-1:0] count_q;
	logic [aabb_pkg::CNT_W-1:0] base;
	logic                       ovf;

	assign box_in.ready = push_ready;
	assign push_valid   = box_in.valid;

	always_comb begin
		base = box_in.data.first_of_frame ? '0 : count_q;
		ovf  = (base >= aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES));
		push_data.box.lo[0] = aabb_pkg::coord_of(box_in.data.min_x);
		push_data.box.lo[1] = aabb_pkg::coord_of(box_in.data.min_y);
		push_data.box.lo[2] = aabb_pkg::coord_of(box_in.data.min_z);
		push_data.box.hi[0] = aabb_pkg::coord_of(box_in.data.max_x);
		push_data.box.hi[1] = aabb_pkg::coord_of(box_in.data.max_y);
		push_data.box.hi[2] = aabb_pkg::coord_of(box_in.data.max_z);
		push_data.idx       = base[aabb_pkg::IDX_W-1:0];
		push_data.overflow  = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (box_in.valid && push_ready) begin
			count_q <= ovf ? base : base + 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/aabb_cmd_fifo.sv =====
// aabb_cmd_fifo: short queue of tagged boxes between the front and the back
// depends on aabb_pkg
`default_nettype none
module aabb_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire aabb_pkg::cmd_t push_data,
	input  wire logic           push_valid,
	output logic                push_ready,
	output aabb_pkg::cmd_t      pop_data,
	output logic                pop_valid,
	input  wire logic           pop_ready
);

	aabb_pkg::cmd_t              slot_q [aabb_pkg::QUEUE_DEPTH];
	logic [aabb_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [aabb_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [aabb_pkg::QCNT_W-1:0] fill_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (fill_q != aabb_pkg::QCNT_W'(aabb_pkg::QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [aabb_pkg::QPTR_W-1:0] next_ptr(
		input logic [aabb_pkg::QPTR_W-1:0] p
	);
		if (p == aabb_pkg::QPTR_W'(aabb_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/aabb_back.sv =====
// aabb_back: box store, one-entry-per-cycle scan against the new box (held while the
// pair output stalls) and the pair output register; depends on aabb_pkg and aabb_if
`default_nettype none
module aabb_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [aabb_pkg::MARGIN_W-1:0] margin,
	input  wire aabb_pkg::cmd_t                pop_data,
	input  wire logic                          pop_valid,
	output logic                               pop_ready,
	aabb_pair_if.source                        pair_out
);

	typedef enum logic [1:0] {IDLE, SCAN, FLUSH} state_t;

	aabb_pkg::entry_t mem [aabb_pkg::MAX_BOXES];

	state_t                     state_q;
	aabb_pkg::cmd_t             cmd_q;
	logic [aabb_pkg::CNT_W-1:0] j_q;
	logic [aabb_pkg::CNT_W-1:0] n_ext;
	aabb_pkg::entry_t           rd_s1;
	logic                       v_s1;
	logic [aabb_pkg::IDX_W-1:0] j_s1;
	logic                       v_s2;
	logic                       hit_s2;
	logic [aabb_pkg::IDX_W-1:0] j_s2;
	logic                       pend_v_q;
	logic [aabb_pkg::IDX_W-1:0] pend_j_q;
	logic                       out_v_q;
	aabb_pkg::result_t          out_q;
	logic                       advance;
	logic                       rd_en;
	logic                       hit_c;

	assign advance        = !out_v_q || pair_out.ready;
	assign pop_ready      = (state_q == IDLE) && advance;
	assign rd_en          = (state_q == SCAN) && advance;
	assign n_ext          = aabb_pkg::CNT_W'(cmd_q.idx);
	assign pair_out.valid = out_v_q;
	assign pair_out.data  = out_q;

	// lo <= hi + m, exact
	function automatic logic le_margin(
		input aabb_pkg::coord_t              lo,
		input aabb_pkg::coord_t              hi,
		input logic [aabb_pkg::MARGIN_W-1:0] m
	);
		logic signed [aabb_pkg::CMP_W-1:0] lo_w;
		logic signed [aabb_pkg::CMP_W-1:0] hi_w;
		logic signed [aabb_pkg::CMP_W-1:0] m_w;
		lo_w = aabb_pkg::CMP_W'(lo);
		hi_w = aabb_pkg::CMP_W'(hi);
		m_w  = signed'({{(aabb_pkg::CMP_W - aabb_pkg::MARGIN_W){1'b0}}, m});
		return lo_w <= hi_w + m_w;
	endfunction

	always_comb begin
		hit_c = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (!le_margin(rd_s1.lo[a], cmd_q.box.hi[a], margin) ||
			    !le_margin(cmd_q.box.lo[a], rd_s1.hi[a], margin)) begin
				hit_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready && !pop_data.overflow) begin
			mem[pop_data.idx] <= pop_data.box;
		end
		if (rd_en) begin
			rd_s1 <= mem[j_q[aabb_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			cmd_q    <= '0;
			j_q      <= '0;
			v_s1     <= 1'b0;
			j_s1     <= '0;
			v_s2     <= 1'b0;
			hit_s2   <= 1'b0;
			j_s2     <= '0;
			pend_v_q <= 1'b0;
			pend_j_q <= '0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
		end else if (advance) begin
			out_v_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (pop_valid) begin
						if (pop_data.overflow) begin
							out_v_q             <= 1'b1;
							out_q.earlier_index <= '0;
							out_q.later_index   <= '0;
							out_q.overflow      <= 1'b1;
							out_q.last          <= 1'b1;
						end else begin
							cmd_q    <= pop_data;
							j_q      <= '0;
							v_s1     <= 1'b0;
							v_s2     <= 1'b0;
							pend_v_q <= 1'b0;
							state_q  <= SCAN;
						end
					end
				end
				SCAN: begin
					v_s1 <= (j_q < n_ext);
					if (j_q < n_ext) begin
						j_s1 <= j_q[aabb_pkg::IDX_W-1:0];
						j_q  <= j_q + 1'b1;
					end
					v_s2   <= v_s1;
					hit_s2 <= hit_c;
					j_s2   <= j_s1;
					if (v_s2 && hit_s2) begin
						if (pend_v_q) begin
							out_v_q             <= 1'b1;
							out_q.earlier_index <= aabb_pkg::OUT_IDX_W'(pend_j_q);
							out_q.later_index   <= aabb_pkg::OUT_IDX_W'(cmd_q.idx);
							out_q.overflow      <= 1'b0;
							out_q.last          <= 1'b0;
						end
						pend_v_q <= 1'b1;
						pend_j_q <= j_s2;
					end
					if (!v_s1 && !v_s2 && (j_q >= n_ext)) begin
						state_q <= FLUSH;
					end
				end
				FLUSH: begin
					if (pend_v_q) begin
						out_v_q             <= 1'b1;
						out_q.earlier_index <= aabb_pkg::OUT_IDX_W'(pend_j_q);
						out_q.later_index   <= aabb_pkg::OUT_IDX_W'(cmd_q.idx);
						out_q.overflow      <= 1'b0;
						out_q.last          <= 1'b1;
					end
					pend_v_q <= 1'b0;
					state_q  <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/aabb_pairwise_overlap_unit.sv =====
// aabb_pairwise_overlap_unit: box in, overlapping index pairs out.
// A box with frame index n is scanned against n stored boxes, one per cycle while the
// output is not stalled; its last pair is registered in FLUSH, after the scan, and the
// next box leaves the queue only once the scan and flush are done. An overflow box is
// not scanned. Reset clears the frame count, the queue, the margin and all control
// state; the box store is not cleared and needs no pass.
`default_nettype none
module aabb_pairwise_overlap_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	aabb_box_if.sink                           box_in,
	aabb_pair_if.source                        pair_out,
	input  wire logic                          cfg_we,
	input  wire logic [aabb_pkg::MARGIN_W-1:0] cfg_wdata
);

	logic [aabb_pkg::MARGIN_W-1:0] margin_q;
	aabb_pkg::cmd_t                push_data;
	logic                          push_valid;
	logic                          push_ready;
	aabb_pkg::cmd_t                pop_data;
	logic                          pop_valid;
	logic                          pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
		end else if (cfg_we) begin
			margin_q <= cfg_wdata;
		end
	end

	aabb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.box_in     (box_in),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	aabb_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	aabb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.margin    (margin_q),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pair_out  (pair_out)
	);

endmodule
`default_nettype wire
